@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/abd_pkg.sv @@
`default_nettype none
package abd_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_CLOSE_SIGMAS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_OPEN_SIGMAS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_BLINK     = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOW_BLINK    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_BLINK     = 3'd4;
    localparam logic [IDX_W-1:0] REG_DOUBLE_GAP    = 3'd5;
    localparam logic [IDX_W-1:0] REG_REFRACTORY    = 3'd6;
    localparam logic [IDX_W-1:0] REG_MIN_WINK      = 3'd7;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [11:0] CLOSE_SIGMAS_RST = 12'd640;
    localparam logic [11:0] OPEN_SIGMAS_RST  = 12'd384;
    localparam logic [15:0] MIN_BLINK_RST    = 16'd40;
    localparam logic [15:0] SLOW_BLINK_RST   = 16'd400;
    localparam logic [15:0] MAX_BLINK_RST    = 16'd800;
    localparam logic [15:0] DOUBLE_GAP_RST   = 16'd300;
    localparam logic [15:0] REFRACTORY_RST   = 16'd60;
    localparam logic [15:0] MIN_WINK_RST     = 16'd60;

    localparam int unsigned BASELINE_ALPHA_DEF  = 655;
    localparam int unsigned DEVIATION_ALPHA_DEF = 1311;
    localparam int unsigned DEVIATION_FLOOR_DEF = 33;

    // Stats are held as 34-bit signed Q2.31 values
    localparam int unsigned STAT_W = 34;
    localparam logic signed [STAT_W-1:0] ONE_Q31   = 34'sd2147483648;
    localparam logic signed [STAT_W-1:0] DEV_RESET = 34'sd64424509;
    localparam logic [15:0] OPEN_MAX = 16'd32768;

    typedef enum logic [1:0] {
        PH_OPEN    = 2'd0,
        PH_CLOSING = 2'd1,
        PH_CLOSED  = 2'd2,
        PH_REFRACT = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THRESH,
        ST_BASE,
        ST_DEV,
        ST_EVENT,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic thresh;
        logic base;
        logic dev;
        logic event_eval;
        logic finish;
        logic eye;
    } dp_cmd_t;

    typedef struct packed {
        logic        blink;
        logic        slow_blink;
        logic        paired_blink;
        logic        left_wink;
        logic        right_wink;
        logic [15:0] blink_duration_ms;
    } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/abd_if.sv @@
`default_nettype none
interface abd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic [15:0] open_left;
    logic [15:0] open_right;
    modport source (output valid, time_ms, open_left, open_right, input ready);
    modport sink (input valid, time_ms, open_left, open_right, output ready);
endinterface

interface abd_out_if;
    logic        valid;
    logic        ready;
    logic        blink;
    logic        slow_blink;
    logic        paired_blink;
    logic        left_wink;
    logic        right_wink;
    logic [15:0] blink_duration_ms;
    modport source (output valid, blink, slow_blink, paired_blink, left_wink, right_wink,
        blink_duration_ms, input ready);
    modport sink (input valid, blink, slow_blink, paired_blink, left_wink, right_wink,
        blink_duration_ms, output ready);
endinterface

interface abd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/adaptive_blink_detector.sv @@
// One sample at a time: no new input word is accepted until the previous
// sample has finished. Steps: accept, then threshold, baseline, deviation
// and phase steps for each eye in turn on the shared unit, then finish.
// A result word not yet taken holds the next sample in its finish step.
// Reset (rst_n, asynchronous): registers at defaults, both eyes open,
// baseline 1.0, deviation 0.03.
`default_nettype none
`include "assert_macros.svh"
module adaptive_blink_detector #(
    parameter int unsigned BASELINE_ALPHA  = abd_pkg::BASELINE_ALPHA_DEF,
    parameter int unsigned DEVIATION_ALPHA = abd_pkg::DEVIATION_ALPHA_DEF,
    parameter int unsigned DEVIATION_FLOOR = abd_pkg::DEVIATION_FLOOR_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    abd_in_if.sink    in_ch,
    abd_out_if.source out_ch,
    abd_cfg_if.sink   cfg
);
    logic [11:0] close_sigmas_reg, open_sigmas_reg;
    logic [15:0] min_blink_reg, slow_blink_reg, max_blink_reg;
    logic [15:0] double_gap_reg, refractory_reg, min_wink_reg;

    logic             busy, res_valid, in_fire, out_fire;
    abd_pkg::dp_cmd_t cmd;
    abd_pkg::result_t result;

    assign in_ch.ready = !busy;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_ch.valid && out_ch.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_sigmas_reg <= abd_pkg::CLOSE_SIGMAS_RST;
            open_sigmas_reg  <= abd_pkg::OPEN_SIGMAS_RST;
            min_blink_reg    <= abd_pkg::MIN_BLINK_RST;
            slow_blink_reg   <= abd_pkg::SLOW_BLINK_RST;
            max_blink_reg    <= abd_pkg::MAX_BLINK_RST;
            double_gap_reg   <= abd_pkg::DOUBLE_GAP_RST;
            refractory_reg   <= abd_pkg::REFRACTORY_RST;
            min_wink_reg     <= abd_pkg::MIN_WINK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                abd_pkg::REG_CLOSE_SIGMAS: close_sigmas_reg <= cfg.data[11:0];
                abd_pkg::REG_OPEN_SIGMAS:  open_sigmas_reg  <= cfg.data[11:0];
                abd_pkg::REG_MIN_BLINK:    min_blink_reg    <= cfg.data;
                abd_pkg::REG_SLOW_BLINK:   slow_blink_reg   <= cfg.data;
                abd_pkg::REG_MAX_BLINK:    max_blink_reg    <= cfg.data;
                abd_pkg::REG_DOUBLE_GAP:   double_gap_reg   <= cfg.data;
                abd_pkg::REG_REFRACTORY:   refractory_reg   <= cfg.data;
                abd_pkg::REG_MIN_WINK:     min_wink_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    abd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .busy      (busy),
        .res_valid (res_valid),
        .cmd       (cmd)
    );

    abd_datapath #(
        .BASELINE_ALPHA  (BASELINE_ALPHA),
        .DEVIATION_ALPHA (DEVIATION_ALPHA),
        .DEVIATION_FLOOR (DEVIATION_FLOOR)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .time_ms       (in_ch.time_ms),
        .open_left     (in_ch.open_left),
        .open_right    (in_ch.open_right),
        .close_sigmas  (close_sigmas_reg),
        .open_sigmas   (open_sigmas_reg),
        .min_blink_ms  (min_blink_reg),
        .slow_blink_ms (slow_blink_reg),
        .max_blink_ms  (max_blink_reg),
        .double_gap_ms (double_gap_reg),
        .refractory_ms (refractory_reg),
        .min_wink_ms   (min_wink_reg),
        .result        (result)
    );

    assign out_ch.valid             = res_valid;
    assign out_ch.blink             = result.blink;
    assign out_ch.slow_blink        = result.slow_blink;
    assign out_ch.paired_blink      = result.paired_blink;
    assign out_ch.left_wink         = result.left_wink;
    assign out_ch.right_wink        = result.right_wink;
    assign out_ch.blink_duration_ms = result.blink_duration_ms;

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, !in_fire, "word accepted while busy")
    `ASSERT_IMPL(a_out_hold, clk, rst_n, $past(out_ch.valid && !out_ch.ready), out_ch.valid && $stable(out_ch.blink_duration_ms), "result word dropped or changed while waiting")
    `ASSERT_ALWAYS(a_wink_excl, clk, rst_n, !(out_ch.valid && out_ch.left_wink && out_ch.right_wink), "both winks set")
    `ASSERT_IMPL(a_wink_blink, clk, rst_n, out_ch.valid && (out_ch.left_wink || out_ch.right_wink), out_ch.blink, "wink without blink")
endmodule
`default_nettype wire

@@ hw/rtl/abd_ctrl.sv @@
`default_nettype none
module abd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            out_fire,
    output logic                 busy,
    output logic                 res_valid,
    output abd_pkg::dp_cmd_t     cmd
);
    abd_pkg::ctrl_state_t state_reg, state_next;
    logic                 eye_reg, eye_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abd_pkg::ST_IDLE;
            eye_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eye_reg       <= eye_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        eye_next       = eye_reg;
        out_valid_next = out_valid_reg && !out_fire;
        cmd            = '0;
        cmd.eye        = eye_reg;
        busy           = 1'b1;
        case (state_reg)
            abd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    eye_next   = 1'b0;
                    state_next = abd_pkg::ST_THRESH;
                end
            end
            abd_pkg::ST_THRESH:
            begin
                cmd.thresh = 1'b1;
                state_next = abd_pkg::ST_BASE;
            end
            abd_pkg::ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = abd_pkg::ST_DEV;
            end
            abd_pkg::ST_DEV:
            begin
                cmd.dev    = 1'b1;
                state_next = abd_pkg::ST_EVENT;
            end
            abd_pkg::ST_EVENT:
            begin
                cmd.event_eval = 1'b1;
                if (eye_reg)
                    state_next = abd_pkg::ST_FINISH;
                else
                begin
                    eye_next   = 1'b1;
                    state_next = abd_pkg::ST_THRESH;
                end
            end
            abd_pkg::ST_FINISH:
            begin
                // hold until the previous result word has left
                if (!out_valid_reg || out_fire)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = abd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = abd_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/abd_datapath.sv @@
`default_nettype none
module abd_datapath #(
    parameter int unsigned BASELINE_ALPHA  = abd_pkg::BASELINE_ALPHA_DEF,
    parameter int unsigned DEVIATION_ALPHA = abd_pkg::DEVIATION_ALPHA_DEF,
    parameter int unsigned DEVIATION_FLOOR = abd_pkg::DEVIATION_FLOOR_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire abd_pkg::dp_cmd_t cmd,
    input  wire logic [31:0]      time_ms,
    input  wire logic [15:0]      open_left,
    input  wire logic [15:0]      open_right,
    input  wire logic [11:0]      close_sigmas,
    input  wire logic [11:0]      open_sigmas,
    input  wire logic [15:0]      min_blink_ms,
    input  wire logic [15:0]      slow_blink_ms,
    input  wire logic [15:0]      max_blink_ms,
    input  wire logic [15:0]      double_gap_ms,
    input  wire logic [15:0]      refractory_ms,
    input  wire logic [15:0]      min_wink_ms,
    output abd_pkg::result_t      result
);
    localparam int unsigned SW = abd_pkg::STAT_W;
    // Thresholds reach down to about -16.0, so they carry four more bits
    localparam int unsigned TW = SW + 4;
    localparam logic signed [SW-1:0] FLOOR_Q31 =
        SW'(DEVIATION_FLOOR) <<< 16;
    localparam logic signed [17:0] BA = 18'(BASELINE_ALPHA);
    localparam logic signed [17:0] DA = 18'(DEVIATION_ALPHA);

    // Per-eye state
    abd_pkg::phase_t         phase_reg [2];
    logic [31:0]             entry_reg [2];
    logic [31:0]             last_end_reg [2];
    logic [1:0]              prev_blink_reg;
    logic signed [SW-1:0]    base_reg [2];
    logic signed [SW-1:0]    dev_reg [2];
    logic [15:0]             last_open_reg [2];

    // Sample working registers
    logic [31:0]             t_reg;
    logic [15:0]             raw_reg [2];
    logic signed [TW-1:0]    thr_close_reg, thr_open_reg;
    logic                    is_close_reg, is_open_reg;
    logic                    ev_blink_reg [2];
    logic                    ev_long_reg, ev_double_reg;
    logic [15:0]             dur_reg [2];
    abd_pkg::result_t        res_reg;

    logic                    e;
    logic [15:0]             o;
    logic signed [SW-1:0]    x;
    logic signed [SW+12:0]   pc, po;
    logic signed [TW-1:0]    thr_c, thr_o;
    logic signed [SW:0]      diff_b, diff_d;
    logic signed [SW+18:0]   prod_b, prod_d;
    logic signed [SW-1:0]    base_new, dev_new, ad;
    logic [31:0]             dur, gap;
    logic                    look_open [2];
    logic                    blink_l, blink_r;
    logic [15:0]             dmax;

    assign e = cmd.eye;
    assign o = (raw_reg[e] > abd_pkg::OPEN_MAX) ? abd_pkg::OPEN_MAX : raw_reg[e];
    assign x = $signed({2'b00, o, 16'h0000});

    // Threshold products: 34 x 13 bits each
    assign pc    = dev_reg[e] * $signed({1'b0, close_sigmas});
    assign po    = dev_reg[e] * $signed({1'b0, open_sigmas});
    assign thr_c = TW'(base_reg[e]) - TW'(pc >>> 8);
    assign thr_o = TW'(base_reg[e]) - TW'(po >>> 8);

    // Floor of alpha * diff / 65536 via arithmetic shift
    assign diff_b   = (SW+1)'(x) - (SW+1)'(base_reg[e]);
    assign prod_b   = diff_b * BA;
    assign base_new = base_reg[e] + SW'(prod_b >>> 16);

    assign ad     = (x >= base_reg[e]) ? x - base_reg[e] : base_reg[e] - x;
    assign diff_d = (SW+1)'(ad) - (SW+1)'(dev_reg[e]);
    assign prod_d = diff_d * DA;
    assign dev_new = dev_reg[e] + SW'(prod_d >>> 16);

    assign dur = t_reg - entry_reg[e];
    assign gap = t_reg - last_end_reg[e];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
            look_open[i] = $signed({2'b00, last_open_reg[i], 16'h0000})
                > (base_reg[i] - dev_reg[i]);
    end

    assign blink_l = ev_blink_reg[0];
    assign blink_r = ev_blink_reg[1];
    assign dmax    = (dur_reg[0] > dur_reg[1]) ? dur_reg[0] : dur_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i]     <= abd_pkg::PH_OPEN;
                entry_reg[i]     <= '0;
                last_end_reg[i]  <= '0;
                base_reg[i]      <= abd_pkg::ONE_Q31;
                dev_reg[i]       <= abd_pkg::DEV_RESET;
                last_open_reg[i] <= abd_pkg::OPEN_MAX;
            end
            prev_blink_reg <= '0;
        end
        else
        begin
            if (cmd.thresh)
                last_open_reg[e] <= o;
            if (cmd.base && x >= thr_open_reg)
                base_reg[e] <= base_new;
            if (cmd.dev)
                dev_reg[e] <= (dev_new < FLOOR_Q31) ? FLOOR_Q31 : dev_new;
            if (cmd.event_eval)
            begin
                case (phase_reg[e])
                    abd_pkg::PH_OPEN:
                        if (is_close_reg)
                        begin
                            phase_reg[e] <= abd_pkg::PH_CLOSING;
                            entry_reg[e] <= t_reg;
                        end
                    abd_pkg::PH_CLOSING:
                        if (is_close_reg)
                        begin
                            phase_reg[e] <= abd_pkg::PH_CLOSED;
                            entry_reg[e] <= t_reg;
                        end
                        else if (is_open_reg)
                            phase_reg[e] <= abd_pkg::PH_OPEN;
                    abd_pkg::PH_CLOSED:
                        if (is_open_reg)
                        begin
                            if (dur >= 32'(min_blink_ms) && dur <= 32'(max_blink_ms))
                            begin
                                prev_blink_reg[e] <= 1'b1;
                                last_end_reg[e]   <= t_reg;
                            end
                            else
                                prev_blink_reg[e] <= 1'b0;
                            phase_reg[e] <= abd_pkg::PH_REFRACT;
                            entry_reg[e] <= t_reg;
                        end
                    default:
                        if (dur >= 32'(refractory_ms))
                            phase_reg[e] <= abd_pkg::PH_OPEN;
                endcase
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg         <= time_ms;
            raw_reg[0]    <= open_left;
            raw_reg[1]    <= open_right;
            ev_long_reg   <= 1'b0;
            ev_double_reg <= 1'b0;
        end
        if (cmd.thresh)
        begin
            thr_close_reg <= thr_c;
            thr_open_reg  <= thr_o;
        end
        if (cmd.base)
        begin
            is_close_reg <= x < thr_close_reg;
            is_open_reg  <= x >= thr_open_reg;
        end
        if (cmd.event_eval)
        begin
            ev_blink_reg[e] <= 1'b0;
            dur_reg[e]      <= '0;
            if (phase_reg[e] == abd_pkg::PH_CLOSED && is_open_reg
                && dur >= 32'(min_blink_ms) && dur <= 32'(max_blink_ms))
            begin
                ev_blink_reg[e] <= 1'b1;
                dur_reg[e]      <= dur[15:0];
                if (dur >= 32'(slow_blink_ms))
                    ev_long_reg <= 1'b1;
                if (prev_blink_reg[e] && gap <= 32'(double_gap_ms))
                    ev_double_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            res_reg.blink        <= blink_l | blink_r;
            res_reg.slow_blink   <= ev_long_reg;
            res_reg.paired_blink <= ev_double_reg;
            res_reg.left_wink    <= blink_l && !blink_r && dur_reg[0] >= min_wink_ms
                && look_open[1];
            res_reg.right_wink   <= blink_r && !blink_l && dur_reg[1] >= min_wink_ms
                && look_open[0];
            res_reg.blink_duration_ms <= dmax;
        end
    end

    assign result = res_reg;
endmodule
`default_nettype wire

@@ dv/adaptive_blink_detector_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module adaptive_blink_detector_tb;

    localparam int unsigned LATENCY = 10;
    localparam longint FLOOR_Q31 = longint'(abd_pkg::DEVIATION_FLOOR_DEF) <<< 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    abd_in_if  in_ch ();
    abd_out_if out_ch ();
    abd_cfg_if cfg ();

    adaptive_blink_detector uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] l;
        logic [15:0] r;
    } sample_t;

    // Directed row: sample plus optional typed-in expectation.
    typedef struct {
        sample_t          s;
        bit               typed;
        abd_pkg::result_t res;
    } row_t;

    // Detector shadow state
    logic [15:0]     thr_regs [abd_pkg::NUM_REGS];
    abd_pkg::phase_t eye_ph [2];
    logic [31:0]     entry_t [2];
    logic [31:0]     last_end [2];
    bit              prev_blink [2];
    longint          base_q [2];
    longint          dev_q [2];
    logic [15:0]     last_open [2];

    abd_pkg::result_t expected_results[$];
    int      errors = 0;
    bit      no_idle = 1'b0;

    function automatic longint ema(longint p, longint v, longint a);
        longint m;
        m = a * (v - p);
        if (m >= 0)
            return p + (m >>> 16);
        return p - ((-m + 65535) >>> 16);
    endfunction

    function automatic logic [3:0] eye_update(int e, logic [31:0] t, logic [15:0] raw,
                                              output logic [31:0] dur_o);
        logic [15:0] o;
        longint x, b, d, tc, to, ad;
        logic [31:0] dur;
        logic [3:0] ev;
        ev = '0;
        dur_o = '0;
        o = (raw > abd_pkg::OPEN_MAX) ? abd_pkg::OPEN_MAX : raw;
        x = longint'(o) <<< 16;
        b = base_q[e];
        d = dev_q[e];
        tc = b - ((d * longint'(thr_regs[abd_pkg::REG_CLOSE_SIGMAS])) >>> 8);
        to = b - ((d * longint'(thr_regs[abd_pkg::REG_OPEN_SIGMAS])) >>> 8);
        last_open[e] = o;
        if (x >= to)
            b = ema(b, x, abd_pkg::BASELINE_ALPHA_DEF);
        ad = x - b;
        if (ad < 0)
            ad = -ad;
        d = ema(d, ad, abd_pkg::DEVIATION_ALPHA_DEF);
        if (d < FLOOR_Q31)
            d = FLOOR_Q31;
        base_q[e] = b;
        dev_q[e] = d;
        case (eye_ph[e])
            abd_pkg::PH_OPEN:
                if (x < tc)
                begin
                    eye_ph[e] = abd_pkg::PH_CLOSING;
                    entry_t[e] = t;
                end
            abd_pkg::PH_CLOSING:
                if (x < tc)
                begin
                    eye_ph[e] = abd_pkg::PH_CLOSED;
                    entry_t[e] = t;
                end
                else if (x >= to)
                    eye_ph[e] = abd_pkg::PH_OPEN;
            abd_pkg::PH_CLOSED:
            begin
                dur = t - entry_t[e];
                if (x >= to)
                begin
                    if (dur >= thr_regs[abd_pkg::REG_MIN_BLINK]
                        && dur <= thr_regs[abd_pkg::REG_MAX_BLINK])
                    begin
                        dur_o = dur;
                        ev[0] = 1'b1;
                        ev[1] = dur >= thr_regs[abd_pkg::REG_SLOW_BLINK];
                        ev[2] = prev_blink[e] &&
                                (t - last_end[e]) <= thr_regs[abd_pkg::REG_DOUBLE_GAP];
                        prev_blink[e] = 1'b1;
                        last_end[e] = t;
                    end
                    else
                        prev_blink[e] = 1'b0;
                    eye_ph[e] = abd_pkg::PH_REFRACT;
                    entry_t[e] = t;
                end
            end
            default:
                if ((t - entry_t[e]) >= thr_regs[abd_pkg::REG_REFRACTORY])
                    eye_ph[e] = abd_pkg::PH_OPEN;
        endcase
        return ev;
    endfunction

    function automatic bit looks_open(int e);
        return (longint'(last_open[e]) <<< 16) > base_q[e] - dev_q[e];
    endfunction

    function automatic abd_pkg::result_t detect_blinks(sample_t s);
        logic [3:0] el, er, ev;
        logic [31:0] dl, dr;
        abd_pkg::result_t r;
        el = eye_update(0, s.t, s.l, dl);
        er = eye_update(1, s.t, s.r, dr);
        ev = el | er;
        r.blink = ev[0];
        r.slow_blink = ev[1];
        r.paired_blink = ev[2];
        r.left_wink = el[0] && !er[0] && dl >= thr_regs[abd_pkg::REG_MIN_WINK]
            && looks_open(1);
        r.right_wink = er[0] && !el[0] && dr >= thr_regs[abd_pkg::REG_MIN_WINK]
            && looks_open(0);
        r.blink_duration_ms = (dl > dr) ? dl[15:0] : dr[15:0];
        return r;
    endfunction

    task automatic reset_shadow();
        thr_regs[abd_pkg::REG_CLOSE_SIGMAS] = 16'(abd_pkg::CLOSE_SIGMAS_RST);
        thr_regs[abd_pkg::REG_OPEN_SIGMAS]  = 16'(abd_pkg::OPEN_SIGMAS_RST);
        thr_regs[abd_pkg::REG_MIN_BLINK]    = abd_pkg::MIN_BLINK_RST;
        thr_regs[abd_pkg::REG_SLOW_BLINK]   = abd_pkg::SLOW_BLINK_RST;
        thr_regs[abd_pkg::REG_MAX_BLINK]    = abd_pkg::MAX_BLINK_RST;
        thr_regs[abd_pkg::REG_DOUBLE_GAP]   = abd_pkg::DOUBLE_GAP_RST;
        thr_regs[abd_pkg::REG_REFRACTORY]   = abd_pkg::REFRACTORY_RST;
        thr_regs[abd_pkg::REG_MIN_WINK]     = abd_pkg::MIN_WINK_RST;
        for (int e = 0; e < 2; e++)
        begin
            eye_ph[e] = abd_pkg::PH_OPEN;
            entry_t[e] = '0;
            last_end[e] = '0;
            prev_blink[e] = 1'b0;
            base_q[e] = longint'(abd_pkg::ONE_Q31);
            dev_q[e] = longint'(abd_pkg::DEV_RESET);
            last_open[e] = abd_pkg::OPEN_MAX;
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        thr_regs[idx] = (idx <= abd_pkg::REG_OPEN_SIGMAS) ? (val & 16'h0FFF) : val;
        @(posedge clk);
    endtask

    // Wait until all words are back and the block has gone quiet.
    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_sample(sample_t s, bit may_idle);
        in_ch.valid <= 1'b1;
        in_ch.time_ms <= s.t;
        in_ch.open_left <= s.l;
        in_ch.open_right <= s.r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(detect_blinks(s));
        if (may_idle && !no_idle && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_idle(sample_t s);
        send_sample(s, 1'b1);
    endtask

    // Receiver: random stalls, compare against oldest expectation.
    initial
    begin
        abd_pkg::result_t want;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.blink !== want.blink)
                    begin
                        $error("blink exp %0d got %0d", want.blink, out_ch.blink);
                        errors++;
                    end
                    if (out_ch.slow_blink !== want.slow_blink)
                    begin
                        $error("slow_blink exp %0d got %0d", want.slow_blink,
                               out_ch.slow_blink);
                        errors++;
                    end
                    if (out_ch.paired_blink !== want.paired_blink)
                    begin
                        $error("paired_blink exp %0d got %0d", want.paired_blink,
                               out_ch.paired_blink);
                        errors++;
                    end
                    if (out_ch.left_wink !== want.left_wink)
                    begin
                        $error("left_wink exp %0d got %0d", want.left_wink,
                               out_ch.left_wink);
                        errors++;
                    end
                    if (out_ch.right_wink !== want.right_wink)
                    begin
                        $error("right_wink exp %0d got %0d", want.right_wink,
                               out_ch.right_wink);
                        errors++;
                    end
                    if (out_ch.blink_duration_ms !== want.blink_duration_ms)
                    begin
                        $error("blink_duration_ms exp %0d got %0d",
                               want.blink_duration_ms, out_ch.blink_duration_ms);
                        errors++;
                    end
                end
            end
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Random burst: open eyes, sometimes a closure on one or both eyes.
    task automatic blink_sequence(ref logic [31:0] now, input int n);
        logic [15:0] lv, rv;
        int close_l, close_r, span;
        for (int i = 0; i < n; i++)
        begin
            span = $urandom_range(1, 8);
            close_l = $urandom_range(0, 2);
            close_r = (close_l == 0) ? $urandom_range(0, 2) :
                      ($urandom_range(0, 2) == 0 ? 0 : close_l);
            // open stretch
            repeat ($urandom_range(2, 6))
            begin
                now += $urandom_range(10, 40);
                send_idle('{now, 16'($urandom_range(31000, 36000)),
                            16'($urandom_range(31000, 36000))});
            end
            // closure stretch
            repeat (span)
            begin
                now += $urandom_range(10, 120);
                lv = close_l ? 16'($urandom_range(0, 8000)) : 16'($urandom_range(31000, 33000));
                rv = close_r ? 16'($urandom_range(0, 8000)) : 16'($urandom_range(31000, 33000));
                send_idle('{now, lv, rv});
            end
        end
    endtask

    initial
    begin
        row_t rows[$];
        row_t rw;
        logic [31:0] now;
        in_ch.valid <= 1'b0;
        in_ch.time_ms <= '0;
        in_ch.open_left <= '0;
        in_ch.open_right <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        reset_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, clamp, left blink (wink), both-eye blink, too short,
        // too long, double blink, wrapped time.
        rows = '{
            '{'{32'd0, 16'hFFFF, 16'hFFFF}, 1'b1, abd_pkg::result_t'('0)},
            '{'{32'd10, 16'h8000, 16'h0000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd20, 16'h8000, 16'h0000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd100, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd300, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd310, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd420, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd700, 16'h0000, 16'h0000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd710, 16'h0000, 16'h0000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd800, 16'h7FFF, 16'h7FFF}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd900, 16'h0000, 16'h0000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd905, 16'h0000, 16'h0000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd910, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd1000, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd1010, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd2500, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd2600, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd2610, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd2700, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd2800, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'hFFFF_FFF0, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'hFFFF_FFF8, 16'h0000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd100, 16'h8000, 16'h8000}, 1'b0, abd_pkg::result_t'('0)},
            '{'{32'd50, 16'h5555, 16'hAAAA}, 1'b0, abd_pkg::result_t'('0)}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            send_idle(rw.s);
            // typed row: first sample after reset can only be quiet
            if (rw.typed && expected_results[$] != rw.res)
            begin
                $error("result word exp %0h predicted %0h", rw.res, expected_results[$]);
                errors++;
            end
        end
        in_ch.valid <= 1'b0;
        drain();

        // Phase sweep over register settings, extremes included.
        now = 32'd5000;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: ;
                1:
                begin
                    write_reg(abd_pkg::REG_CLOSE_SIGMAS, 16'hFFFF);
                    write_reg(abd_pkg::REG_OPEN_SIGMAS, 16'h0000);
                    write_reg(abd_pkg::REG_MIN_BLINK, 16'h0000);
                    write_reg(abd_pkg::REG_SLOW_BLINK, 16'hFFFF);
                    write_reg(abd_pkg::REG_MAX_BLINK, 16'hFFFF);
                    write_reg(abd_pkg::REG_DOUBLE_GAP, 16'hFFFF);
                    write_reg(abd_pkg::REG_REFRACTORY, 16'h0000);
                    write_reg(abd_pkg::REG_MIN_WINK, 16'h0000);
                end
                2:
                begin
                    write_reg(abd_pkg::REG_CLOSE_SIGMAS, 16'd256);
                    write_reg(abd_pkg::REG_OPEN_SIGMAS, 16'd128);
                    write_reg(abd_pkg::REG_MIN_BLINK, 16'd20);
                    write_reg(abd_pkg::REG_SLOW_BLINK, 16'd150);
                    write_reg(abd_pkg::REG_MAX_BLINK, 16'd400);
                    write_reg(abd_pkg::REG_DOUBLE_GAP, 16'd600);
                    write_reg(abd_pkg::REG_REFRACTORY, 16'd15);
                    write_reg(abd_pkg::REG_MIN_WINK, 16'd30);
                end
                3:
                begin
                    write_reg(abd_pkg::REG_CLOSE_SIGMAS, 16'h0000);
                    write_reg(abd_pkg::REG_OPEN_SIGMAS, 16'hFFFF);
                    write_reg(abd_pkg::REG_MIN_BLINK, 16'hFFFF);
                    write_reg(abd_pkg::REG_MAX_BLINK, 16'h0000);
                    write_reg(abd_pkg::REG_DOUBLE_GAP, 16'h0000);
                    write_reg(abd_pkg::REG_REFRACTORY, 16'hFFFF);
                    write_reg(abd_pkg::REG_MIN_WINK, 16'hFFFF);
                end
                default:
                    for (int k = 0; k < abd_pkg::NUM_REGS; k++)
                        write_reg(k[2:0], 16'($urandom_range(0, 65535)));
            endcase
            if (ph == 5)
            begin
                // back to a sensitive setup, no idling for the tail
                write_reg(abd_pkg::REG_CLOSE_SIGMAS, 16'd384);
                write_reg(abd_pkg::REG_OPEN_SIGMAS, 16'd200);
                write_reg(abd_pkg::REG_MIN_BLINK, 16'd30);
                write_reg(abd_pkg::REG_MAX_BLINK, 16'd500);
                write_reg(abd_pkg::REG_REFRACTORY, 16'd20);
                write_reg(abd_pkg::REG_MIN_WINK, 16'd40);
                no_idle = 1'b1;
            end
            for (int j = 0; j < 17; j++)
            begin
                blink_sequence(now, 1);
                // noise words
                repeat (2)
                begin
                    now = ($urandom_range(0, 9) == 0) ? $urandom() : now + $urandom_range(0, 200);
                    send_idle('{now, 16'($urandom()), 16'($urandom())});
                end
            end
            in_ch.valid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
